### rtl/assert_macros.svh
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/mmh_pkg.sv
package mmh_pkg;

	localparam int Capacity = 128;
	localparam int KeyBits = 32;
	localparam int IdxBits = $clog2(Capacity);
	localparam int CntBits = $clog2(Capacity + 1);

	typedef logic [IdxBits-1:0] idx_t;
	typedef logic [CntBits-1:0] cnt_t;
	typedef logic signed [KeyBits-1:0] key_t;

	localparam logic [1:0] CmdInsert = 2'd0;
	localparam logic [1:0] CmdRemMin = 2'd1;
	localparam logic [1:0] CmdRemMax = 2'd2;

	localparam logic [1:0] StDone  = 2'd0;
	localparam logic [1:0] StFull  = 2'd1;
	localparam logic [1:0] StEmpty = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		key_t       key_value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		key_t       min_key;
		key_t       max_key;
		logic [7:0] entry_count;
	} rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_SWP,
		S_GUP_RD,
		S_GUP_CMP,
		S_GUP_SWP,
		S_REM_RD,
		S_REM_HOLE,
		S_DN_RD,
		S_DN_CMP,
		S_DN_SWP,
		S_DN_PRD,
		S_DN_PCMP,
		S_DN_PSWP,
		S_SUM_RD,
		S_SUM_CMP,
		S_OUT
	} state_t;

	// level parity: true on a min level (floor(log2(i+1)) even)
	function automatic logic on_min_level(input idx_t i);
		logic [IdxBits:0] n;
		logic             par;
		n = {1'b0, i} + 1'b1;
		par = 1'b0;
		for (int b = 0; b <= IdxBits; b++) begin
			if (n[b]) begin
				par = b[0];
			end
		end
		return !par;
	endfunction

endpackage

### rtl/min_max_heap_engine.sv
// Min-max heap engine: double-ended priority store of signed keys.
// Requests enter on req (valid/stall): insert a key, remove the minimum or
// remove the maximum. Every request yields exactly one response on rsp
// carrying status, current minimum and maximum (0 when empty) and count.
// Keys live in a RAM with registered reads and one read per cycle, so
// a request walks the heap one access at a time, in these steps:
//   no-op, full insert, empty removal, insert into an empty store: the
//     closing summary only;
//   insert: the parent check, a parent swap if needed, grandparent steps,
//     a final write and the closing summary;
//   removal: pick the slot and fill the hole, then per sink level a move
//     to a grandchild (six candidate reads and compares, swap, parent
//     check), a move to a child, a stay, or an end with no children,
//     and the closing summary.
// One request is in flight at a time: req_stall is high while busy, so a
// new request is taken only once the last one is through.
// Reset clears state, fill count and rsp_valid; slots above it go unused.
// When rsp is stalled the response register holds; the next request is
// still taken and processed, then waits for the register before finishing.
module min_max_heap_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mmh_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mmh_pkg::rsp_t  rsp
);
	import mmh_pkg::*;
	`include "assert_macros.svh"

	state_t state_q, state_d;
	cnt_t   count_q, count_d;
	req_t   cmd_q, cmd_d;
	idx_t   cur_q, cur_d;
	idx_t   oth_q, oth_d;
	idx_t   best_q, best_d;
	key_t   cur_key_q, cur_key_d;
	key_t   best_key_q, best_key_d;
	key_t   tmp_key_q, tmp_key_d;
	logic   maxm_q, maxm_d;
	logic [2:0] k_q, k_d;
	logic [1:0] st_q, st_d;
	logic   rv_q, rv_d;
	rsp_t   rsp_q, rsp_d;
	key_t   mn_q, mn_d;

	logic   we;
	idx_t   waddr, raddr;
	key_t   wdata, rdata;

	mmh_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

	function automatic logic better(input key_t a, input key_t b, input logic mx);
		return mx ? (b < a) : (a < b);
	endfunction

	logic [IdxBits+2:0] c1w, candw;
	always_comb begin
		c1w = {2'b0, cur_q, 1'b1};
		case (k_q)
			3'd0: candw = c1w;
			3'd1: candw = {c1w[IdxBits+1:0], 1'b1};
			3'd2: candw = {c1w[IdxBits+1:0], 1'b0} + 2'd2;
			3'd3: candw = c1w + 1'b1;
			3'd4: candw = {c1w[IdxBits+1:0], 1'b0} + 2'd3;
			default: candw = {c1w[IdxBits+1:0], 1'b0} + 3'd4;
		endcase
	end
	logic cand_ok;
	assign cand_ok = (candw < {{(IdxBits+3-CntBits){1'b0}}, count_q});

	idx_t gp;
	assign gp = idx_t'((((cur_q - 1'b1) >> 1) - 1'b1) >> 1);
	idx_t par_best;
	assign par_best = idx_t'((best_q - 1'b1) >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rv_q <= rv_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d; cur_q <= cur_d; oth_q <= oth_d; best_q <= best_d;
		cur_key_q <= cur_key_d; best_key_q <= best_key_d; tmp_key_q <= tmp_key_d;
		maxm_q <= maxm_d; k_q <= k_d; st_q <= st_d; rsp_q <= rsp_d; mn_q <= mn_d;
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rv_q;
	assign rsp = rsp_q;

	always_comb begin
		state_d = state_q; count_d = count_q; cmd_d = cmd_q; cur_d = cur_q;
		oth_d = oth_q; best_d = best_q; cur_key_d = cur_key_q;
		best_key_d = best_key_q; tmp_key_d = tmp_key_q; maxm_d = maxm_q;
		k_d = k_q; st_d = st_q; rsp_d = rsp_q; mn_d = mn_q;
		rv_d = rv_q && rsp_stall;
		we = 1'b0; waddr = cur_q; wdata = cur_key_q; raddr = cur_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd_d = req;
					st_d = StDone;
					state_d = S_SUM_RD;
					if (req.command == CmdInsert) begin
						if (count_q >= cnt_t'(Capacity)) begin
							st_d = StFull;
						end else begin
							we = 1'b1;
							waddr = idx_t'(count_q);
							wdata = req.key_value;
							cur_d = idx_t'(count_q);
							cur_key_d = req.key_value;
							count_d = count_q + 1'b1;
							if (count_q != '0) begin
								state_d = S_INS_RD;
							end
						end
					end else if (req.command == CmdRemMin || req.command == CmdRemMax) begin
						if (count_q == '0) begin
							st_d = StEmpty;
						end else begin
							cur_d = '0;
							k_d = 3'd0;
							state_d = S_REM_RD;
						end
					end
				end
			end
			// insert: compare with parent
			S_INS_RD: begin
				raddr = idx_t'((cur_q - 1'b1) >> 1);
				state_d = S_INS_CMP;
			end
			S_INS_CMP: begin
				oth_d = idx_t'((cur_q - 1'b1) >> 1);
				tmp_key_d = rdata;
				if (better(cur_key_q, rdata, on_min_level(cur_q))) begin
					state_d = S_INS_SWP;
				end else begin
					maxm_d = !on_min_level(cur_q);
					state_d = S_GUP_RD;
				end
			end
			S_INS_SWP: begin
				we = 1'b1; waddr = cur_q; wdata = tmp_key_q;
				maxm_d = !on_min_level(oth_q);
				cur_d = oth_q;
				state_d = S_GUP_RD;
			end
			S_GUP_RD: begin
				raddr = gp;
				if (cur_q < idx_t'(3)) begin
					we = 1'b1; waddr = cur_q; wdata = cur_key_q;
					state_d = S_SUM_RD;
				end else begin
					state_d = S_GUP_CMP;
				end
			end
			S_GUP_CMP: begin
				tmp_key_d = rdata;
				oth_d = gp;
				if (better(cur_key_q, rdata, maxm_q)) begin
					state_d = S_GUP_SWP;
				end else begin
					we = 1'b1; waddr = cur_q; wdata = cur_key_q;
					state_d = S_SUM_RD;
				end
			end
			S_GUP_SWP: begin
				we = 1'b1; waddr = cur_q; wdata = tmp_key_q;
				cur_d = oth_q;
				state_d = S_GUP_RD;
			end
			// removal: pick the slot, k steps through reads of 1, 2 and the last slot
			S_REM_RD: begin
				case (k_q)
					3'd0: raddr = idx_t'(1);
					3'd1: raddr = idx_t'(2);
					default: raddr = idx_t'(count_q - 1'b1);
				endcase
				k_d = k_q + 1'b1;
				if (k_q == 3'd1) begin
					best_key_d = rdata;
					cur_d = (cmd_q.command == CmdRemMax && count_q >= cnt_t'(2))
						? idx_t'(1) : idx_t'(0);
				end
				if (k_q == 3'd2) begin
					if (cmd_q.command == CmdRemMax && count_q >= cnt_t'(3)
						&& best_key_q < rdata) begin
						cur_d = idx_t'(2);
					end
				end
				if (k_q == 3'd3) begin
					state_d = S_REM_HOLE;
				end
			end
			S_REM_HOLE: begin
				cur_key_d = rdata;
				count_d = count_q - 1'b1;
				maxm_d = !on_min_level(cur_q);
				we = 1'b1; waddr = cur_q; wdata = rdata;
				k_d = 3'd0;
				state_d = (cnt_t'(cur_q) < count_q - 1'b1) ? S_DN_RD : S_SUM_RD;
			end
			// sink: scan six candidates, reading and comparing one at a time
			S_DN_RD: begin
				raddr = idx_t'(candw);
				if (k_q == 3'd0 && !cand_ok) begin
					state_d = S_SUM_RD;
				end else if (k_q == 3'd6) begin
					state_d = S_DN_SWP;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (k_q == 3'd0 || (cand_ok && better(rdata, best_key_q, maxm_q))) begin
					best_key_d = rdata;
					best_d = idx_t'(candw);
				end
				k_d = k_q + 1'b1;
				state_d = S_DN_RD;
			end
			S_DN_SWP: begin
				if (!better(best_key_q, cur_key_q, maxm_q)) begin
					state_d = S_SUM_RD;
				end else begin
					we = 1'b1; waddr = cur_q; wdata = best_key_q;
					if ({1'b0, best_q} <= {cur_q, 1'b0} + 2'd2) begin
						waddr = cur_q; wdata = best_key_q;
						tmp_key_d = cur_key_q;
						state_d = S_DN_PSWP;
						oth_d = best_q;
					end else begin
						state_d = S_DN_PRD;
					end
				end
			end
			S_DN_PRD: begin
				raddr = par_best;
				state_d = S_DN_PCMP;
			end
			S_DN_PCMP: begin
				k_d = 3'd0;
				cur_d = best_q;
				if (better(rdata, cur_key_q, maxm_q)) begin
					we = 1'b1; waddr = par_best; wdata = cur_key_q;
					cur_key_d = rdata;
				end
				state_d = S_DN_PSWP;
				oth_d = best_q;
				tmp_key_d = better(rdata, cur_key_q, maxm_q) ? rdata : cur_key_q;
			end
			S_DN_PSWP: begin
				// write the moving key at its new slot, continue if deeper
				we = 1'b1; waddr = oth_q; wdata = tmp_key_q;
				k_d = 3'd0;
				if (cur_q == oth_q) begin
					state_d = S_DN_RD;
				end else begin
					state_d = S_SUM_RD;
				end
			end
			// summary: read root, then children
			S_SUM_RD: begin
				raddr = '0;
				k_d = 3'd0;
				state_d = S_SUM_CMP;
				best_d = '0;
			end
			S_SUM_CMP: begin
				raddr = (best_q == '0) ? idx_t'(1) : idx_t'(2);
				if (best_q == '0) begin
					mn_d = rdata; best_key_d = rdata;
					best_d = idx_t'(1);
				end else if (best_q == idx_t'(1)) begin
					if (count_q >= cnt_t'(2)) best_key_d = rdata;
					best_d = idx_t'(2);
				end else begin
					if (count_q >= cnt_t'(3) && best_key_q < rdata) best_key_d = rdata;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				// hold until the previous response has been taken
				if (!(rv_q && rsp_stall)) begin
					rsp_d.status = st_q;
					rsp_d.min_key = (count_q == '0) ? '0 : mn_q;
					rsp_d.max_key = (count_q == '0) ? '0 : best_key_q;
					rsp_d.entry_count = 8'(count_q);
					rv_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`ASSERT_IMPL(a_no_overfill, clk, arst_n, 1'b1, count_q <= cnt_t'(Capacity))
	`ASSERT_IMPL(a_busy_stalls, clk, arst_n, state_q != S_IDLE, req_stall)
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, req_valid && !req_stall, state_q != S_IDLE)

endmodule

### rtl/mmh_ram.sv
module mmh_ram (
	input  logic          clk,
	input  logic          we,
	input  mmh_pkg::idx_t waddr,
	input  mmh_pkg::key_t wdata,
	input  mmh_pkg::idx_t raddr,
	output mmh_pkg::key_t rdata
);
	import mmh_pkg::*;

	key_t mem [Capacity];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### dv/min_max_heap_engine_test.sv
module min_max_heap_engine_test;
	import mmh_pkg::*;

	localparam int Cap = Capacity;
	localparam logic [1:0] CmdUnused = 2'd3;

	// golden min-max heap kept beside the block
	class heap_scoreboard;
		key_t   slots [Cap];
		int     fill;
		rsp_t   expected [int];
		int     wr_n;
		int     rd_n;
		int     mismatches;

		function new();
			fill = 0;
			wr_n = 0;
			rd_n = 0;
			mismatches = 0;
		endfunction

		function automatic int outstanding();
			return wr_n - rd_n;
		endfunction

		function automatic bit better(key_t a, key_t b, bit max_mode);
			return max_mode ? (a > b) : (a < b);
		endfunction

		function automatic bit min_level(int i);
			int n;
			int l;
			n = i + 1;
			l = 0;
			while (n > 1) begin
				n = n >> 1;
				l++;
			end
			return (l % 2) == 0;
		endfunction

		function automatic void swap(int a, int b);
			key_t t;
			t = slots[a];
			slots[a] = slots[b];
			slots[b] = t;
		endfunction

		function automatic void climb_grand(int i, bit max_mode);
			int g;
			while (i >= 3) begin
				g = (((i - 1) >> 1) - 1) >> 1;
				if (!better(slots[i], slots[g], max_mode)) break;
				swap(i, g);
				i = g;
			end
		endfunction

		function automatic void climb(int i);
			int p;
			bit ml;
			if (i == 0) return;
			p = (i - 1) >> 1;
			ml = min_level(i);
			if (better(slots[i], slots[p], ml)) begin
				swap(i, p);
				climb_grand(p, ml);
			end else begin
				climb_grand(i, !ml);
			end
		endfunction

		function automatic void sink(int i);
			bit mx;
			int c1;
			int c2;
			int best;
			int p;
			int cand [6];
			mx = !min_level(i);
			forever begin
				c1 = 2 * i + 1;
				c2 = 2 * i + 2;
				if (c1 >= fill) return;
				cand = '{c1, 2 * c1 + 1, 2 * c1 + 2, c2, 2 * c2 + 1, 2 * c2 + 2};
				best = c1;
				for (int k = 1; k < 6; k++)
					if (cand[k] < fill && better(slots[cand[k]], slots[best], mx))
						best = cand[k];
				if (!better(slots[best], slots[i], mx)) return;
				swap(best, i);
				if (best <= c2) return;
				p = (best - 1) >> 1;
				if (better(slots[p], slots[best], mx)) swap(best, p);
				i = best;
			end
		endfunction

		function automatic void take_out(int idx);
			fill--;
			slots[idx] = slots[fill];
			if (idx < fill) sink(idx);
		endfunction

		function automatic void note_request(req_t r);
			rsp_t e;
			int idx;
			e = '0;
			if (r.command == CmdInsert) begin
				if (fill >= Cap) begin
					e.status = StFull;
				end else begin
					slots[fill] = r.key_value;
					fill++;
					climb(fill - 1);
				end
			end else if (r.command == CmdRemMin || r.command == CmdRemMax) begin
				if (fill == 0) begin
					e.status = StEmpty;
				end else if (r.command == CmdRemMin) begin
					take_out(0);
				end else begin
					idx = 0;
					if (fill >= 2) idx = 1;
					if (fill >= 3 && slots[1] < slots[2]) idx = 2;
					take_out(idx);
				end
			end
			if (fill > 0) begin
				e.min_key = slots[0];
				e.max_key = slots[0];
				if (fill >= 2) e.max_key = slots[1];
				if (fill >= 3 && e.max_key < slots[2]) e.max_key = slots[2];
			end
			e.entry_count = fill[7:0];
			expected[wr_n] = e;
			wr_n++;
		endfunction

		function automatic void check_response(rsp_t got);
			rsp_t e;
			if (outstanding() == 0) begin
				report(got, '0, 1'b1);
				return;
			end
			e = expected[rd_n];
			expected.delete(rd_n);
			rd_n++;
			if (got.status !== e.status || got.min_key !== e.min_key ||
			    got.max_key !== e.max_key || got.entry_count !== e.entry_count)
				report(got, e, 1'b0);
		endfunction

		function automatic void report(rsp_t got, rsp_t e, bit unexpected);
			mismatches++;
			if (mismatches > 10) return;
			if (unexpected) begin
				$display("unexpected response: st=%0d min=%0d max=%0d cnt=%0d",
					got.status, got.min_key, got.max_key, got.entry_count);
			end else begin
				$display("mismatch: exp st=%0d min=%0d max=%0d cnt=%0d",
					e.status, e.min_key, e.max_key, e.entry_count);
				$display("          got st=%0d min=%0d max=%0d cnt=%0d",
					got.status, got.min_key, got.max_key, got.entry_count);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	heap_scoreboard sb;
	int  idle_cycles;
	bit  hold_rsp;

	min_max_heap_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// present one request, hold until taken, then an optional gap
	task automatic send(logic [1:0] cmd, key_t k, bit gaps);
		int g;
		req_valid <= 1'b1;
		req.command <= cmd;
		req.key_value <= k;
		do @(posedge clk); while (req_stall);
		sb.note_request('{cmd, k});
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			req_valid <= 1'b0;
			req <= '{2'($urandom_range(0, 3)), key_t'($urandom)};
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	function automatic key_t rand_key();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'sh7fffffff;
		if (r == 1) return 32'sh80000000;
		if (r < 5) return $urandom_range(0, 20) - 10;
		return $urandom;
	endfunction

	function automatic logic [1:0] rand_cmd(int fill_bias);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) return CmdUnused;
		if (r < fill_bias) return CmdInsert;
		return (r % 2) ? CmdRemMin : CmdRemMax;
	endfunction

	// response side: random stalls, or a long hold when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) sb.check_response(rsp);
			if (hold_rsp) rsp_stall <= 1'b1;
			else if ($urandom_range(0, 99) < 8) rsp_stall <= 1'b1;
			else if ($urandom_range(0, 99) < 40) rsp_stall <= 1'b0;
			else rsp_stall <= ($urandom_range(0, 99) < 25);
		end
	end

	// nothing accepted for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		sb = new();
		hold_rsp = 1'b0;
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty removals, extremes, unused code, ties
		send(CmdRemMin, 32'sh0, 1'b0);
		send(CmdRemMax, -32'sh1, 1'b0);
		send(CmdUnused, 32'sh5, 1'b0);
		send(CmdInsert, 32'sh7fffffff, 1'b0);
		send(CmdRemMax, 32'sh0, 1'b0);
		send(CmdInsert, 32'sh80000000, 1'b0);
		send(CmdInsert, 32'sh7fffffff, 1'b0);
		send(CmdInsert, 32'sh0, 1'b0);
		send(CmdInsert, 32'sh0, 1'b0);
		send(CmdInsert, -32'sh1, 1'b0);
		send(CmdUnused, -32'sh1, 1'b0);
		send(CmdRemMax, 32'sh0, 1'b0);
		send(CmdRemMin, 32'sh0, 1'b0);
		send(CmdRemMin, 32'sh0, 1'b0);
		send(CmdRemMax, 32'sh0, 1'b0);
		send(CmdRemMin, 32'sh0, 1'b0);
		send(CmdRemMin, 32'sh0, 1'b0);
		drain();

		// fill to capacity and beyond, the response side holding off at the start
		fork
			begin
				hold_rsp = 1'b1;
				repeat (300) @(posedge clk);
				hold_rsp = 1'b0;
			end
			begin
				for (int i = 0; i < Cap + 4; i++) send(CmdInsert, rand_key(), 1'b1);
			end
		join
		drain();
		repeat (2) send(CmdInsert, rand_key(), 1'b1);

		// random mix, drifting between draining and filling
		for (int i = 0; i < 470; i++) begin
			send(rand_cmd(((i / 150) % 2) ? 70 : 35), rand_key(), 1'b1);
			if (i == 300) drain();
		end
		// empty it completely
		for (int i = 0; i < Cap + 2; i++)
			send(i % 2 ? CmdRemMin : CmdRemMax, rand_key(), 1'b1);
		drain();

		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
